// ===== rtl/core/mmrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mmrt_pkg: shared types and codes of the minimum-metric route table
// Field widths, mode, status and command codes, table entry and queued
// command layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package mmrt_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;

	localparam int MODE_W = 3;
	localparam int VID_W  = 64;
	localparam int HOP_W  = 32;
	localparam int MET_W  = 16;
	localparam int ST_W   = 3;
	localparam int KIND_W = 3;

	// Input modes.
	localparam logic [MODE_W-1:0] MODE_LEARN = 3'd0;
	localparam logic [MODE_W-1:0] MODE_RMALL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_RMONE = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LIST  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROUTE = 3'd4;

	// Result status codes.
	localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
	localparam logic [ST_W-1:0] ST_ROUTE    = 3'd1;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd2;
	localparam logic [ST_W-1:0] ST_BCAST    = 3'd3;
	localparam logic [ST_W-1:0] ST_DROP     = 3'd4;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd5;

	// Classified command kinds carried through the queue.
	localparam logic [KIND_W-1:0] K_LEARN = 3'd0;
	localparam logic [KIND_W-1:0] K_RMALL = 3'd1;
	localparam logic [KIND_W-1:0] K_RMONE = 3'd2;
	localparam logic [KIND_W-1:0] K_LIST  = 3'd3;
	localparam logic [KIND_W-1:0] K_ROUTE = 3'd4;
	localparam logic [KIND_W-1:0] K_DROP  = 3'd5;
	localparam logic [KIND_W-1:0] K_NOP   = 3'd6;

	typedef struct packed {
		logic [VID_W-1:0] vid;
		logic [HOP_W-1:0] hop;
		logic [MET_W-1:0] met;
	} entry_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [VID_W-1:0]  key;
		logic [VID_W-1:0]  dest;
		logic [HOP_W-1:0]  hop;
		logic [MET_W-1:0]  met;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/mmrt_ram.sv =====
// ----------------------------------------------------------------------------
// mmrt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mmrt_front.sv =====
// ----------------------------------------------------------------------------
// mmrt_front: input side of the route table
// Accepts input beats, classifies them into commands against the metric
// limit and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrt_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [mmrt_pkg::MODE_W-1:0] mode,
	input  wire logic [mmrt_pkg::VID_W-1:0]  key_vid,
	input  wire logic [mmrt_pkg::VID_W-1:0]  dest_vid,
	input  wire logic [mmrt_pkg::HOP_W-1:0]  neighbor_addr,
	input  wire logic [mmrt_pkg::MET_W-1:0]  metric,
	input  wire logic                        cfg_wr_en,
	input  wire logic [mmrt_pkg::MET_W-1:0]  cfg_wr_data,
	output logic                             q_vld,
	output mmrt_pkg::cmd_t                   q_cmd,
	input  wire logic                        q_pop
);

	logic [mmrt_pkg::MET_W-1:0] limit_q;
	mmrt_pkg::cmd_t             fifo_q [2];
	mmrt_pkg::cmd_t             new_cmd;
	logic                       wr_ptr_q;
	logic                       rd_ptr_q;
	logic [1:0]                 cnt_q;
	logic                       push;
	logic                       pop;

	// Metric limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// Classify the incoming beat.
	always_comb begin
		new_cmd.key  = key_vid;
		new_cmd.dest = dest_vid;
		new_cmd.hop  = neighbor_addr;
		new_cmd.met  = metric;
		unique case (mode)
			mmrt_pkg::MODE_LEARN: new_cmd.kind = mmrt_pkg::K_LEARN;
			mmrt_pkg::MODE_RMALL: new_cmd.kind = mmrt_pkg::K_RMALL;
			mmrt_pkg::MODE_RMONE: new_cmd.kind = mmrt_pkg::K_RMONE;
			mmrt_pkg::MODE_LIST:  new_cmd.kind = mmrt_pkg::K_LIST;
			mmrt_pkg::MODE_ROUTE: begin
				new_cmd.kind = (metric > limit_q) ? mmrt_pkg::K_DROP : mmrt_pkg::K_ROUTE;
			end
			default: new_cmd.kind = mmrt_pkg::K_NOP;
		endcase
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && (cnt_q != 2'd0);
	assign q_vld    = (cnt_q != 2'd0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/mmrt_back.sv =====
// ----------------------------------------------------------------------------
// mmrt_back: table engine of the route table
// Runs each queued command other than drop and no-op as one or more scans over
// the entry RAM and delivers result beats through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mmrt_back #(
	parameter int TABLE_ENTRIES = mmrt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       q_vld,
	input  wire mmrt_pkg::cmd_t             q_cmd,
	output logic                            q_pop,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [mmrt_pkg::ST_W-1:0]       status,
	output logic [mmrt_pkg::HOP_W-1:0]      hop_addr,
	output logic [mmrt_pkg::MET_W-1:0]      hop_metric,
	output logic                            last
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int KW = mmrt_pkg::MET_W + AW;
	localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_END  = 2'd2;

	localparam logic [1:0] P_LEARN = 2'd0;
	localparam logic [1:0] P_RMALL = 2'd1;
	localparam logic [1:0] P_RMONE = 2'd2;
	localparam logic [1:0] P_BEST  = 2'd3;

	logic [1:0]                    state_q;
	logic [1:0]                    ptype_q;
	mmrt_pkg::cmd_t                cmd_q;
	logic [AW-1:0]                 cnt_q;
	logic                          issuing_q;
	logic                          rd_en_s1;
	logic [AW-1:0]                 slot_s1;
	logic [TABLE_ENTRIES-1:0]      valid_q;
	logic                          hit_q;
	logic [AW-1:0]                 hit_slot_q;
	logic [mmrt_pkg::MET_W-1:0]    hit_met_q;
	logic [mmrt_pkg::HOP_W-1:0]    hit_hop_q;
	logic                          free_vld_q;
	logic [AW-1:0]                 free_slot_q;
	logic                          any_q;
	logic                          have_prev_q;
	logic [KW-1:0]                 prev_q;
	logic                          pend_vld_q;
	logic [mmrt_pkg::HOP_W-1:0]    pend_hop_q;
	logic [mmrt_pkg::MET_W-1:0]    pend_met_q;
	logic                          out_vld_q;
	logic [mmrt_pkg::ST_W-1:0]     st_q;
	logic [mmrt_pkg::HOP_W-1:0]    hop_q;
	logic [mmrt_pkg::MET_W-1:0]    met_q;
	logic                          last_q;

	logic [$bits(mmrt_pkg::entry_t)-1:0] ram_rdata;
	mmrt_pkg::entry_t              ent;
	logic [mmrt_pkg::VID_W-1:0]    vid_cmp;
	logic                          ent_v;
	logic                          m_vid;
	logic                          m_hop;
	logic                          m_met;
	logic [KW-1:0]                 ent_key;
	logic [KW-1:0]                 best_key;
	logic                          above;
	logic                          better;
	logic                          scan_hit;
	logic                          scan_free;
	logic                          scan_clr;
	logic                          scan_last;

	logic                          out_free;
	logic                          emit_need;
	logic [mmrt_pkg::ST_W-1:0]     emit_st;
	logic [mmrt_pkg::HOP_W-1:0]    emit_hop;
	logic [mmrt_pkg::MET_W-1:0]    emit_met;
	logic                          emit_last;
	logic                          learn_wr;
	logic                          wr_en;
	logic [AW-1:0]                 wr_slot;
	logic                          set_valid;
	logic                          restart;
	logic                          restart_list;
	logic                          finish;
	logic                          advance;
	logic [1:0]                    idle_ptype;
	logic                          idle_scan;
	mmrt_pkg::entry_t              wr_ent;

	// Entry storage.
	mmrt_ram #(
		.WIDTH ($bits(mmrt_pkg::entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_slot),
		.wdata (wr_ent),
		.re    (issuing_q),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	// Compare the entry returned by the RAM against the command.
	always_comb begin
		ent      = mmrt_pkg::entry_t'(ram_rdata);
		vid_cmp  = (cmd_q.kind == mmrt_pkg::K_ROUTE && ptype_q == P_BEST) ?
			cmd_q.dest : cmd_q.key;
		ent_v    = valid_q[slot_s1];
		m_vid    = ent_v && (ent.vid == vid_cmp);
		m_hop    = (ent.hop == cmd_q.hop);
		m_met    = (ent.met == cmd_q.met);
		ent_key  = {ent.met, slot_s1};
		best_key = {hit_met_q, hit_slot_q};
		above    = !have_prev_q || (ent_key > prev_q);
		better   = !hit_q || (ent_key < best_key);
		scan_hit = rd_en_s1 && (
			(ptype_q == P_LEARN && m_vid && m_hop && !hit_q) ||
			(ptype_q == P_RMONE && m_vid && m_hop && m_met && !hit_q) ||
			(ptype_q == P_BEST && m_vid && above && better));
		scan_free = rd_en_s1 && (ptype_q == P_LEARN) && !ent_v && !free_vld_q;
		scan_clr  = rd_en_s1 && (
			(ptype_q == P_RMALL && m_vid) ||
			(ptype_q == P_RMONE && m_vid && m_hop && m_met && !hit_q));
		scan_last = rd_en_s1 && (slot_s1 == LAST_SLOT);
	end

	// Pass type for a command taken from the queue.
	always_comb begin
		idle_scan = 1'b1;
		unique case (q_cmd.kind)
			mmrt_pkg::K_LEARN: idle_ptype = P_LEARN;
			mmrt_pkg::K_RMALL: idle_ptype = P_RMALL;
			mmrt_pkg::K_RMONE: idle_ptype = P_RMONE;
			mmrt_pkg::K_LIST:  idle_ptype = P_BEST;
			mmrt_pkg::K_ROUTE: idle_ptype = P_LEARN;
			default: begin
				idle_ptype = P_LEARN;
				idle_scan  = 1'b0;
			end
		endcase
	end

	// Decide what the end of a pass does.
	always_comb begin
		emit_need    = 1'b0;
		emit_st      = mmrt_pkg::ST_DONE;
		emit_hop     = '0;
		emit_met     = '0;
		emit_last    = 1'b1;
		learn_wr     = 1'b0;
		restart      = 1'b0;
		restart_list = 1'b0;
		finish       = 1'b0;
		unique case (cmd_q.kind)
			mmrt_pkg::K_LEARN: begin
				learn_wr  = 1'b1;
				emit_need = 1'b1;
				emit_st   = (!hit_q && !free_vld_q) ? mmrt_pkg::ST_FULL : mmrt_pkg::ST_DONE;
				finish    = 1'b1;
			end
			mmrt_pkg::K_ROUTE: begin
				if (ptype_q == P_LEARN) begin
					learn_wr = 1'b1;
					restart  = 1'b1;
				end else begin
					emit_need = 1'b1;
					emit_st   = hit_q ? mmrt_pkg::ST_ROUTE : mmrt_pkg::ST_BCAST;
					emit_hop  = hit_q ? hit_hop_q : '0;
					emit_met  = hit_q ? hit_met_q : '0;
					finish    = 1'b1;
				end
			end
			mmrt_pkg::K_RMALL: begin
				emit_need = 1'b1;
				emit_st   = any_q ? mmrt_pkg::ST_DONE : mmrt_pkg::ST_NOTFOUND;
				finish    = 1'b1;
			end
			mmrt_pkg::K_RMONE: begin
				emit_need = 1'b1;
				emit_st   = hit_q ? mmrt_pkg::ST_DONE : mmrt_pkg::ST_NOTFOUND;
				finish    = 1'b1;
			end
			mmrt_pkg::K_LIST: begin
				if (hit_q) begin
					// The pending route is known not to be the last one.
					emit_need    = pend_vld_q;
					emit_st      = mmrt_pkg::ST_ROUTE;
					emit_hop     = pend_hop_q;
					emit_met     = pend_met_q;
					emit_last    = 1'b0;
					restart      = 1'b1;
					restart_list = 1'b1;
				end else begin
					emit_need = 1'b1;
					emit_st   = pend_vld_q ? mmrt_pkg::ST_ROUTE : mmrt_pkg::ST_NOTFOUND;
					emit_hop  = pend_vld_q ? pend_hop_q : '0;
					emit_met  = pend_vld_q ? pend_met_q : '0;
					finish    = 1'b1;
				end
			end
			mmrt_pkg::K_DROP: begin
				emit_need = 1'b1;
				emit_st   = mmrt_pkg::ST_DROP;
				finish    = 1'b1;
			end
			default: begin
				emit_need = 1'b1;
				finish    = 1'b1;
			end
		endcase
	end

	assign out_free  = !out_vld_q || !out_stall;
	assign advance   = (state_q == S_END) && (!emit_need || out_free);
	assign q_pop     = (state_q == S_IDLE) && q_vld;

	// Learn write: lower the metric of a match or fill the lowest free slot.
	assign wr_en     = advance && learn_wr &&
		(hit_q ? (hit_met_q > cmd_q.met) : free_vld_q);
	assign wr_slot   = hit_q ? hit_slot_q : free_slot_q;
	assign set_valid = advance && learn_wr && !hit_q && free_vld_q;
	assign wr_ent    = '{vid: cmd_q.key, hop: cmd_q.hop, met: cmd_q.met};

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptype_q     <= P_LEARN;
			cnt_q       <= '0;
			issuing_q   <= 1'b0;
			rd_en_s1    <= 1'b0;
			valid_q     <= '0;
			hit_q       <= 1'b0;
			free_vld_q  <= 1'b0;
			any_q       <= 1'b0;
			have_prev_q <= 1'b0;
			pend_vld_q  <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			rd_en_s1 <= issuing_q;
			if (issuing_q) begin
				if (cnt_q == LAST_SLOT) begin
					issuing_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + AW'(1);
				end
			end
			if (scan_hit) begin
				hit_q <= 1'b1;
			end
			if (scan_free) begin
				free_vld_q <= 1'b1;
			end
			if (scan_clr) begin
				valid_q[slot_s1] <= 1'b0;
				any_q            <= 1'b1;
			end
			if (set_valid) begin
				valid_q[free_slot_q] <= 1'b1;
			end
			if (advance && emit_need) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_vld) begin
						pend_vld_q  <= 1'b0;
						have_prev_q <= 1'b0;
						ptype_q     <= idle_ptype;
						if (idle_scan) begin
							state_q    <= S_SCAN;
							cnt_q      <= '0;
							issuing_q  <= 1'b1;
							hit_q      <= 1'b0;
							free_vld_q <= 1'b0;
							any_q      <= 1'b0;
						end else begin
							state_q <= S_END;
						end
					end
				end
				S_SCAN: begin
					if (scan_last) begin
						state_q <= S_END;
					end
				end
				S_END: begin
					if (advance) begin
						if (restart) begin
							state_q    <= S_SCAN;
							ptype_q    <= P_BEST;
							cnt_q      <= '0;
							issuing_q  <= 1'b1;
							hit_q      <= 1'b0;
							free_vld_q <= 1'b0;
							any_q      <= 1'b0;
							if (restart_list) begin
								have_prev_q <= 1'b1;
								pend_vld_q  <= 1'b1;
							end
						end else if (finish) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command, pass and result payload.
	always_ff @(posedge clk) begin
		slot_s1 <= cnt_q;
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (scan_hit) begin
			hit_slot_q <= slot_s1;
			hit_met_q  <= ent.met;
			hit_hop_q  <= ent.hop;
		end
		if (scan_free) begin
			free_slot_q <= slot_s1;
		end
		if (advance && restart_list) begin
			prev_q     <= best_key;
			pend_hop_q <= hit_hop_q;
			pend_met_q <= hit_met_q;
		end
		if (advance && emit_need) begin
			st_q   <= emit_st;
			hop_q  <= emit_hop;
			met_q  <= emit_met;
			last_q <= emit_last;
		end
	end

	assign out_valid  = out_vld_q;
	assign status     = st_q;
	assign hop_addr   = hop_q;
	assign hop_metric = met_q;
	assign last       = last_q;

	// A free slot found by a learn scan really is unused.
	a_free_slot_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ptype_q == P_LEARN && free_vld_q) |-> !valid_q[free_slot_q])
		else $error("learn scan recorded a used slot as free");

	// The best route of a lookup scan stays a live entry.
	a_best_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ptype_q == P_BEST && hit_q) |-> valid_q[hit_slot_q])
		else $error("lookup scan holds an invalid best entry");

	// The entry taken out by remove-one is cleared once found.
	a_rmone_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ptype_q == P_RMONE && hit_q) |-> !valid_q[hit_slot_q])
		else $error("remove-one match still valid");

	// Only a list command keeps a pending route.
	a_pend_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && pend_vld_q) |-> (cmd_q.kind == mmrt_pkg::K_LIST))
		else $error("pending route outside a list command");

endmodule

`default_nettype wire

// ===== rtl/core/min_metric_route_table_unit.sv =====
// ----------------------------------------------------------------------------
// min_metric_route_table_unit: minimum-metric route table
// Keeps destination, neighbor and metric entries and answers learn, remove,
// list and route commands from scans of the entry RAM.
// ----------------------------------------------------------------------------
// Each scan reads one RAM slot per cycle over all TABLE_ENTRIES slots.
// Learn and remove items take one scan each.
// Route takes two scans, a learn scan and then a lookup scan; drop takes none.
// List of r routes takes r + 1 scans and gives one beat per route.
// A two-beat queue takes items while the engine works; one item runs at a time.
// Reset clears all entry valid flags at once and sets metric_limit to 65535.
`default_nettype none

module min_metric_route_table_unit #(
	parameter int TABLE_ENTRIES = mmrt_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [mmrt_pkg::MODE_W-1:0] mode,
	input  wire logic [mmrt_pkg::VID_W-1:0]  key_vid,
	input  wire logic [mmrt_pkg::VID_W-1:0]  dest_vid,
	input  wire logic [mmrt_pkg::HOP_W-1:0]  neighbor_addr,
	input  wire logic [mmrt_pkg::MET_W-1:0]  metric,
	input  wire logic                        cfg_wr_en,
	input  wire logic [mmrt_pkg::MET_W-1:0]  cfg_wr_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [mmrt_pkg::ST_W-1:0]        status,
	output logic [mmrt_pkg::HOP_W-1:0]       hop_addr,
	output logic [mmrt_pkg::MET_W-1:0]       hop_metric,
	output logic                             last
);

	logic           q_vld;
	logic           q_pop;
	mmrt_pkg::cmd_t q_cmd;

	// Input classification and command queue.
	mmrt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.key_vid       (key_vid),
		.dest_vid      (dest_vid),
		.neighbor_addr (neighbor_addr),
		.metric        (metric),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.q_vld         (q_vld),
		.q_cmd         (q_cmd),
		.q_pop         (q_pop)
	);

	// Table engine and result register.
	mmrt_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_vld      (q_vld),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.hop_addr   (hop_addr),
		.hop_metric (hop_metric),
		.last       (last)
	);

endmodule

`default_nettype wire
